// File: src/ws2812_pixel_serializer_assert.svh
`ifndef WS2812_PIXEL_SERIALIZER_ASSERT_SVH
`define WS2812_PIXEL_SERIALIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WPS_ASSERT_NOW(label, clk, off, ante, cons) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
      else $error("ws2812 serializer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define WPS_ASSERT_NEXT(label, clk, off, ante, cons) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
      else $error("ws2812 serializer check failed");

`endif

// File: src/wps_pkg.sv
package wps_pkg;

   localparam int CHAN_W         = 8;
   localparam int PIXEL_W        = 3 * CHAN_W;
   localparam int PROD_W         = 2 * CHAN_W;
   localparam int CNT_W          = 5;
   localparam int RSP_DATA_W     = 8;
   localparam int BITS_PER_PIXEL = PIXEL_W;
   localparam logic [CHAN_W-1:0] FULL_SCALE      = 8'd255;
   localparam logic [CHAN_W-1:0] BRIGHTNESS_INIT = FULL_SCALE;
   localparam logic [CNT_W-1:0]  CNT_LOAD        = CNT_W'(BITS_PER_PIXEL);
   localparam logic [CNT_W-1:0]  CNT_FINAL       = CNT_W'(1);

   // Pixel waiting between the scaling lanes and the serializer.
   typedef struct packed {
      logic valid;
      logic last_pixel;
   } pixel_stage_type;

endpackage

// File: src/wps_scale_lane.sv
module wps_scale_lane
   import wps_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [CHAN_W-1:0] brightness,
   input  logic [CHAN_W-1:0] channel,
   output logic [CHAN_W-1:0] scaled
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;
   logic [PROD_W-1:0] approx_sum;
   logic [CHAN_W-1:0] quot_est;
   logic [PROD_W:0]   quot_times_scale;
   logic [PROD_W:0]   remainder;
   logic [CHAN_W:0]   quot_fixed;

   assign product_in = PROD_W'(brightness) * PROD_W'(channel);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   // Divide by 255: estimate with a shift-add, then one compare and correct.
   assign approx_sum       = product_ff + (product_ff >> CHAN_W);
   assign quot_est         = approx_sum[PROD_W-1:CHAN_W];
   assign quot_times_scale = {1'b0, quot_est, {CHAN_W{1'b0}}} - (PROD_W+1)'(quot_est);
   assign remainder        = {1'b0, product_ff} - quot_times_scale;

   always_comb begin
      if (remainder >= (PROD_W+1)'(FULL_SCALE)) begin
         quot_fixed = {1'b0, quot_est} + (CHAN_W+1)'(1);
      end else begin
         quot_fixed = {1'b0, quot_est};
      end
   end

   assign scaled = quot_fixed[CHAN_W-1:0];

endmodule

// File: src/wps_bit_serializer.sv
module wps_bit_serializer
   import wps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pixel_stage_type    stage,
   input  logic [PIXEL_W-1:0] word,
   input  logic               rsp_ready,
   output logic               load,
   output logic               rsp_valid,
   output logic               line_bit,
   output logic               is_latch,
   output logic               run_last
);

   logic               busy_ff,        busy_in;
   logic [PIXEL_W-1:0] shift_ff,       shift_in;
   logic [CNT_W-1:0]   count_ff,       count_in;
   logic               latch_pend_ff,  latch_pend_in;
   logic               latch_phase_ff, latch_phase_in;

   logic take;
   logic final_bit;
   logic finish;
   logic to_latch;

   assign take      = busy_ff && rsp_ready;
   assign final_bit = (count_ff == CNT_FINAL);
   assign finish    = take && (latch_phase_ff || (final_bit && !latch_pend_ff));
   assign to_latch  = take && !latch_phase_ff && final_bit && latch_pend_ff;
   // Pull the next pixel in the same cycle the current one drains.
   assign load      = stage.valid && (!busy_ff || finish);

   always_comb begin
      busy_in        = busy_ff;
      shift_in       = shift_ff;
      count_in       = count_ff;
      latch_pend_in  = latch_pend_ff;
      latch_phase_in = latch_phase_ff;
      priority if (load) begin
         busy_in        = 1'b1;
         shift_in       = word;
         count_in       = CNT_LOAD;
         latch_pend_in  = stage.last_pixel;
         latch_phase_in = 1'b0;
      end else if (finish) begin
         busy_in        = 1'b0;
         latch_phase_in = 1'b0;
      end else if (to_latch) begin
         latch_phase_in = 1'b1;
         latch_pend_in  = 1'b0;
      end else if (take) begin
         shift_in = {shift_ff[PIXEL_W-2:0], 1'b0};
         count_in = count_ff - CNT_FINAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         count_ff       <= '0;
         latch_pend_ff  <= 1'b0;
         latch_phase_ff <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         count_ff       <= count_in;
         latch_pend_ff  <= latch_pend_in;
         latch_phase_ff <= latch_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp_valid = busy_ff;
   assign line_bit  = latch_phase_ff ? 1'b0 : shift_ff[PIXEL_W-1];
   assign is_latch  = latch_phase_ff;
   assign run_last  = latch_phase_ff || (final_bit && !latch_pend_ff);

endmodule

// File: src/ws2812_pixel_serializer.sv
// Path: a pixel's first line bit is offered once the scaling lane product register and
// then the serializer shift register have loaded; that load waits for a free serializer.
// Throughput: 24 result transfers per pixel, 25 when the pixel closes a frame; the
// shift register gives one bit per ready cycle, and the next pixel loads without a gap.
// Three scaling lanes (multiply, then divide by 255) feed the shift register.
// Reset: synchronous, active high; clears the pipeline and sets brightness to 255.
module ws2812_pixel_serializer
   import wps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,  // red [7:0], green [15:8], blue [23:16]
   input  logic                  req_tlast,  // last_pixel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // line_bit [0], zero fill [7:1]
   output logic                  rsp_tuser,  // is_latch
   output logic                  rsp_tlast,  // run_last
   input  logic                  csr_we,
   input  logic [CHAN_W-1:0]     csr_wdata
);

   logic [CHAN_W-1:0] brightness_ff;
   logic              stage_valid_ff, stage_valid_in;
   logic              stage_last_ff;
   logic              req_take;
   logic              load;
   logic              line_bit;
   logic [CHAN_W-1:0] red_scaled;
   logic [CHAN_W-1:0] green_scaled;
   logic [CHAN_W-1:0] blue_scaled;
   logic [PIXEL_W-1:0] merged_word;
   pixel_stage_type   stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_INIT;
      end else if (csr_we) begin
         brightness_ff <= csr_wdata;
      end
   end

   assign req_take   = req_tvalid && req_tready;
   assign req_tready = !stage_valid_ff || load;

   always_comb begin
      priority if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (load) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_last_ff <= req_tlast;
      end
   end

   wps_scale_lane u_lane_red (
      .clock      (clock),
      .enable     (req_take),
      .brightness (brightness_ff),
      .channel    (req_tdata[CHAN_W-1:0]),
      .scaled     (red_scaled)
   );

   wps_scale_lane u_lane_green (
      .clock      (clock),
      .enable     (req_take),
      .brightness (brightness_ff),
      .channel    (req_tdata[2*CHAN_W-1:CHAN_W]),
      .scaled     (green_scaled)
   );

   wps_scale_lane u_lane_blue (
      .clock      (clock),
      .enable     (req_take),
      .brightness (brightness_ff),
      .channel    (req_tdata[3*CHAN_W-1:2*CHAN_W]),
      .scaled     (blue_scaled)
   );

   // Merge lanes in line order: green goes out first.
   assign merged_word = {green_scaled, red_scaled, blue_scaled};

   assign stage.valid      = stage_valid_ff;
   assign stage.last_pixel = stage_last_ff;

   wps_bit_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .word      (merged_word),
      .rsp_ready (rsp_tready),
      .load      (load),
      .rsp_valid (rsp_tvalid),
      .line_bit  (line_bit),
      .is_latch  (rsp_tuser),
      .run_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, line_bit};

endmodule

// File: src/wps_checker.sv
`include "ws2812_pixel_serializer_assert.svh"

module wps_checker
   import wps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast
);

   logic                  rsp_stall;
   logic [RSP_DATA_W+1:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};

   `WPS_ASSERT_NOW(a_latch_is_low, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

   `WPS_ASSERT_NOW(a_latch_ends_run, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   `WPS_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, !rsp_tvalid)

   `WPS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

endmodule

bind ws2812_pixel_serializer wps_checker u_wps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
